// ===== hw/rtl/lora_toa_pkg.sv =====
package lora_toa_pkg;

  localparam int unsigned PAYLOAD_W  = 8;
  localparam int unsigned AIRTIME_W  = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SF        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CR        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LDRO      = 3'd6;

  // Bandwidth codes
  localparam logic [3:0] BW_125K = 4'd7;
  localparam logic [3:0] BW_250K = 4'd8;
  localparam logic [3:0] BW_500K = 4'd9;

  localparam logic [3:0] SF_MIN = 4'd6;
  localparam logic [3:0] SF_MAX = 4'd12;

  // floor(y / 125) = (y * DIV125_MAGIC) >> DIV125_SHIFT, exact for y < 2^30
  localparam logic [30:0] DIV125_MAGIC = 31'd1099511628;
  localparam int unsigned DIV125_SHIFT = 37;

  // One queued word: everything the back end needs for one packet
  typedef struct packed {
    logic       bad_bw;
    logic       num_pos;
    logic [7:0] quo;
    logic [2:0] cr;
    logic [15:0] preamble;
    logic [3:0] shift;
  } lora_toa_item_t;

  // ceil(2^16 / e) for the symbol divisor e = sf - 2*ldro, 4..12
  function automatic logic [14:0] recip_q16(input logic [3:0] e);
    logic [14:0] r;
    case (e)
      4'd4:    r = 15'd16384;
      4'd5:    r = 15'd13108;
      4'd6:    r = 15'd10923;
      4'd7:    r = 15'd9363;
      4'd8:    r = 15'd8192;
      4'd9:    r = 15'd7282;
      4'd10:   r = 15'd6554;
      4'd11:   r = 15'd5958;
      4'd12:   r = 15'd5462;
      default: r = 15'd16384;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/lora_toa_front.sv =====
module lora_toa_front import lora_toa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAYLOAD_W-1:0]  payload_bytes_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [CW-1:0]         q_count_i,
  output logic                  push_o,
  output lora_toa_item_t        item_o
);

  logic [3:0]  bw_q, sf_q;
  logic [2:0]  cr_q;
  logic [15:0] pre_q;
  logic        crc_q, impl_q, ldro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q   <= BW_125K;
      sf_q   <= 4'd7;
      cr_q   <= 3'd1;
      pre_q  <= 16'd8;
      crc_q  <= 1'b1;
      impl_q <= 1'b0;
      ldro_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BANDWIDTH: bw_q   <= cfg_data_i[3:0];
        CFG_SF:        sf_q   <= cfg_data_i[3:0];
        CFG_CR:        cr_q   <= cfg_data_i[2:0];
        CFG_PREAMBLE:  pre_q  <= cfg_data_i;
        CFG_CRC:       crc_q  <= cfg_data_i[0];
        CFG_IMPLICIT:  impl_q <= cfg_data_i[0];
        CFG_LDRO:      ldro_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify: clamp SF, decode bandwidth, form the rounded-up dividend
  logic [3:0]         sf_c, e_c, k_c, shift_c;
  logic               bad_c, num_pos_c;
  logic signed [12:0] num_c;
  logic [11:0]        num_r;
  logic [9:0]         b_c;
  logic               accept;

  assign accept = start && !busy;

  always_comb begin
    if (sf_q < SF_MIN)      sf_c = SF_MIN;
    else if (sf_q > SF_MAX) sf_c = SF_MAX;
    else                    sf_c = sf_q;

    bad_c = 1'b0;
    case (bw_q)
      BW_125K: k_c = 4'd0;
      BW_250K: k_c = 4'd1;
      BW_500K: k_c = 4'd2;
      default: begin
        k_c   = 4'd0;
        bad_c = 1'b1;
      end
    endcase
    shift_c = sf_c - k_c;

    num_c = $signed({2'b00, payload_bytes_i, 3'b000})
          - $signed({7'd0, sf_c, 2'b00})
          + 13'sd28
          + (crc_q ? 13'sd16 : 13'sd0)
          - (impl_q ? 13'sd20 : 13'sd0);
    num_pos_c = !num_c[12] && (num_c != 13'sd0);

    // ceil(num / 4e) = floor((ceil(num / 4) + e - 1) / e)
    e_c   = sf_c - (ldro_q ? 4'd2 : 4'd0);
    num_r = num_c[11:0] + 12'd3;
    b_c   = num_r[11:2] + {6'd0, e_c} - 10'd1;
  end

  logic           f1_v_q;
  logic [9:0]     f1_b_q;
  logic [3:0]     f1_e_q;
  lora_toa_item_t f1_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f1_v_q <= 1'b0;
    else         f1_v_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_b_q             <= b_c;
      f1_e_q             <= e_c;
      f1_item_q.bad_bw   <= bad_c;
      f1_item_q.num_pos  <= num_pos_c;
      f1_item_q.quo      <= 8'd0;
      f1_item_q.cr       <= cr_q;
      f1_item_q.preamble <= pre_q;
      f1_item_q.shift    <= shift_c;
    end
  end

  // Divide by the symbol divisor through its reciprocal
  logic [24:0]    quo_prod;
  logic           f2_v_q;
  lora_toa_item_t f2_item_d, f2_item_q;

  assign quo_prod = f1_b_q * recip_q16(f1_e_q);

  always_comb begin
    f2_item_d     = f1_item_q;
    f2_item_d.quo = quo_prod[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f2_v_q <= 1'b0;
    else         f2_v_q <= f1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (f1_v_q) begin
      f2_item_q <= f2_item_d;
    end
  end

  assign push_o = f2_v_q;
  assign item_o = f2_item_q;

  // Hold off new packets while the queue could not take all in flight
  logic [CW+1:0] credit_use;
  assign credit_use = (CW+2)'(q_count_i) + (CW+2)'(f1_v_q) + (CW+2)'(f2_v_q);
  assign busy       = credit_use >= (CW+2)'(QUEUE_DEPTH);

endmodule

// ===== hw/rtl/lora_toa_queue.sv =====
module lora_toa_queue import lora_toa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned PW = $clog2(QUEUE_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lora_toa_item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output lora_toa_item_t item_o,
  output logic [CW-1:0]  count_o
);

  lora_toa_item_t mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop)      count_q <= count_q + 1'b1;
      else if (!push_i && do_pop) count_q <= count_q - 1'b1;
    end
  end

  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/lora_toa_back.sv =====
module lora_toa_back import lora_toa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  lora_toa_item_t       item_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic [AIRTIME_W-1:0] airtime_ms_o
);

  // Quarter symbols, scaled to 500*ms, doubled to 1000*ms and biased so the result rounds up
  logic [11:0] pay_full;
  logic [10:0] pay_sym;
  logic [18:0] quarters;
  logic [30:0] scaled;
  logic [32:0] biased;

  always_comb begin
    pay_full = item_i.num_pos ? item_i.quo * ({1'b0, item_i.cr} + 4'd4) : 12'd0;
    pay_sym  = pay_full[10:0] + 11'd8;
    quarters = {1'b0, item_i.preamble, 2'b00} + 19'd17 + {6'd0, pay_sym, 2'b00};
    scaled   = 31'(quarters) << item_i.shift;
    biased   = {1'b0, scaled, 1'b0} + 33'd999;
  end

  assign pop_o = valid_i;

  logic        b1_v_q, b1_bad_q;
  logic [29:0] y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b1_v_q <= 1'b0;
    else         b1_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      y_q      <= biased[32:3];
      b1_bad_q <= item_i.bad_bw;
    end
  end

  // floor(y / 125) by reciprocal multiply
  logic [60:0]          div_prod;
  logic                 done_q;
  logic [AIRTIME_W-1:0] airtime_q;

  assign div_prod = y_q * DIV125_MAGIC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= b1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (b1_v_q) begin
      airtime_q <= b1_bad_q ? '0 : div_prod[DIV125_SHIFT +: AIRTIME_W];
    end
  end

  assign done_o       = done_q;
  assign airtime_ms_o = airtime_q;

endmodule

// ===== hw/rtl/lora_time_on_air_core.sv =====
// Channel   Direction  Handshake                 Word
// ------    ---------  ------------------------  ------------------------------
// request   in         start high, busy low      payload_bytes_i
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
// result    out        done_o strobe, one cycle  airtime_ms_o
//
// One packet a cycle while busy is low; an accepted start reaches done_o through the stages below.
// Front end (two stages) decodes settings and divides by the symbol divisor,
// the queue adds one register, back end (two stages) scales and divides by 125
// with a reciprocal multiply.
// The queue drains every cycle, so busy only rises if QUEUE_DEPTH is below 4.
// Reset clears control state and loads the default modem settings.
// The receiver cannot stall; results are never held back.
module lora_time_on_air_core import lora_toa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAYLOAD_W-1:0]  payload_bytes_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [AIRTIME_W-1:0]  airtime_ms_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic           push, pop, head_valid;
  lora_toa_item_t push_item, head_item;
  logic [CW-1:0]  q_count;

  assign cfg_ready_o = 1'b1;

  lora_toa_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .payload_bytes_i(payload_bytes_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_count_i      (q_count),
    .push_o         (push),
    .item_o         (push_item)
  );

  lora_toa_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .valid_o(head_valid),
    .item_o (head_item),
    .count_o(q_count)
  );

  lora_toa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .item_i      (head_item),
    .pop_o       (pop),
    .done_o      (done_o),
    .airtime_ms_o(airtime_ms_o)
  );

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("accepted packet did not complete in 5 cycles");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CW'(1))
    else $error("queue backed up although the back end never stalls");

  a_pop_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> ##2 done_o)
    else $error("popped word did not reach the output");

endmodule
